// ----- design/sic_pkg.sv -----
package sic_pkg;

    // width of every index-like field on the ports
    localparam int FIELD_BITS = 32;

    // result queue: room for the two words one input word can cause, plus slack
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic                  out_valid;
        logic [FIELD_BITS-1:0] merged_begin;
        logic [FIELD_BITS-1:0] merged_end;
        logic [FIELD_BITS-1:0] offset_in_set;
        logic                  is_final;
        logic [FIELD_BITS-1:0] total_elements;
        logic [FIELD_BITS-1:0] largest_position;
        logic                  order_error;
    } result_t;

endpackage

// ----- design/sorted_interval_coalescer_top.sv -----
// result words are registered in the result queue and offered behind any words already waiting there
// throughput: one input word per cycle while s_ready is high; a word that closes a range and ends the list
// makes two result words, which leave one at a time through the result queue
// s_ready follows free space in the four-word result queue
// reset (aresetn low, synchronous) empties the queue and clears all merge state
module sorted_interval_coalescer_top import sic_pkg::*; #(
    parameter int INDEX_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FIELD_BITS-1:0] s_range_begin,
    input  logic [FIELD_BITS-1:0] s_range_end,
    input  logic                  s_is_last_range,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_out_valid,
    output logic [FIELD_BITS-1:0] m_merged_begin,
    output logic [FIELD_BITS-1:0] m_merged_end,
    output logic [FIELD_BITS-1:0] m_offset_in_set,
    output logic                  m_is_final,
    output logic [FIELD_BITS-1:0] m_total_elements,
    output logic [FIELD_BITS-1:0] m_largest_position,
    output logic                  m_order_error
);

    logic       in_fire;
    result_t    res0, res1;
    logic [1:0] res_count;
    result_t    head;

    // a word is taken when it is valid and the queue can hold both of its possible results
    assign in_fire = s_valid & s_ready;

    // merge state and the results of the incoming word
    sic_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_begin  (s_range_begin),
        .in_end    (s_range_end),
        .in_last   (s_is_last_range),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    // result queue parts the input side from a stalled output
    sic_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (in_fire),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .room       (s_ready),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_data   (head)
    );

    // unpack the head of the queue onto the result ports
    assign m_out_valid        = head.out_valid;
    assign m_merged_begin     = head.merged_begin;
    assign m_merged_end       = head.merged_end;
    assign m_offset_in_set    = head.offset_in_set;
    assign m_is_final         = head.is_final;
    assign m_total_elements   = head.total_elements;
    assign m_largest_position = head.largest_position;
    assign m_order_error      = head.order_error;

endmodule

// ----- design/sic_core.sv -----
module sic_core import sic_pkg::*; #(
    parameter int INDEX_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic [FIELD_BITS-1:0] in_begin,
    input  logic [FIELD_BITS-1:0] in_end,
    input  logic                  in_last,
    output result_t               res0,
    output result_t               res1,
    output logic [1:0]            res_count
);

    typedef logic [INDEX_BITS-1:0] idx_t;

    logic have_reg,  have_next;
    idx_t first_reg, first_next;
    idx_t last_reg,  last_next;
    idx_t offset_reg, offset_next;
    idx_t count_reg, count_next;
    idx_t lsize_reg, lsize_next;
    idx_t lord_reg,  lord_next;
    idx_t prev_reg,  prev_next;
    logic fault_reg, fault_next;

    idx_t    b, e;
    logic    nonempty, merge, close_mid;
    logic    have1;
    idx_t    first1, last1;
    idx_t    size_mid, size_fin;
    idx_t    offset1, count1, lsize1, lord1;
    idx_t    total_fin, lord_fin;
    result_t mid_res, fin_res;

    always_comb begin
        b = INDEX_BITS'(in_begin);
        e = INDEX_BITS'(in_end);

        nonempty   = b < e;
        fault_next = fault_reg | (nonempty & (b < prev_reg));
        merge      = nonempty & have_reg & (b <= last_reg);
        close_mid  = nonempty & have_reg & ~merge;

        // current range after this word
        have1  = have_reg | nonempty;
        first1 = first_reg;
        last1  = last_reg;
        if (merge) begin
            if (e > last_reg) begin
                last1 = e;
            end
        end else if (nonempty) begin
            first1 = b;
            last1  = e;
        end

        // closing the previous range when this one starts past it
        size_mid = last_reg - first_reg;
        offset1  = offset_reg;
        count1   = count_reg;
        lsize1   = lsize_reg;
        lord1    = lord_reg;
        if (close_mid) begin
            offset1 = offset_reg + size_mid;
            count1  = count_reg + idx_t'(1);
            if (size_mid > lsize_reg) begin
                lsize1 = size_mid;
                lord1  = count_reg;
            end
        end

        // flush on the last word
        size_fin  = last1 - first1;
        total_fin = offset1 + size_fin;
        lord_fin  = (size_fin > lsize1) ? count1 : lord1;

        mid_res                  = '0;
        mid_res.out_valid        = 1'b1;
        mid_res.merged_begin     = FIELD_BITS'(first_reg);
        mid_res.merged_end       = FIELD_BITS'(last_reg);
        mid_res.offset_in_set    = FIELD_BITS'(offset_reg);
        mid_res.order_error      = fault_next;

        fin_res                  = '0;
        fin_res.is_final         = 1'b1;
        fin_res.order_error      = fault_next;
        if (have1) begin
            fin_res.out_valid        = 1'b1;
            fin_res.merged_begin     = FIELD_BITS'(first1);
            fin_res.merged_end       = FIELD_BITS'(last1);
            fin_res.offset_in_set    = FIELD_BITS'(offset1);
            fin_res.total_elements   = FIELD_BITS'(total_fin);
            fin_res.largest_position = FIELD_BITS'(lord_fin);
        end

        res0      = close_mid ? mid_res : fin_res;
        res1      = fin_res;
        res_count = {1'b0, close_mid} + {1'b0, in_last};

        // next state; end of list returns everything to reset
        if (in_last) begin
            have_next   = 1'b0;
            first_next  = '0;
            last_next   = '0;
            offset_next = '0;
            count_next  = '0;
            lsize_next  = '0;
            lord_next   = '0;
            prev_next   = '0;
        end else begin
            have_next   = have1;
            first_next  = first1;
            last_next   = last1;
            offset_next = offset1;
            count_next  = count1;
            lsize_next  = lsize1;
            lord_next   = lord1;
            prev_next   = nonempty ? b : prev_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg   <= 1'b0;
            first_reg  <= '0;
            last_reg   <= '0;
            offset_reg <= '0;
            count_reg  <= '0;
            lsize_reg  <= '0;
            lord_reg   <= '0;
            prev_reg   <= '0;
            fault_reg  <= 1'b0;
        end else if (in_fire) begin
            have_reg   <= have_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            offset_reg <= offset_next;
            count_reg  <= count_next;
            lsize_reg  <= lsize_next;
            lord_reg   <= lord_next;
            prev_reg   <= prev_next;
            fault_reg  <= in_last ? 1'b0 : fault_next;
        end
    end

endmodule

// ----- design/sic_outq.sv -----
module sic_outq import sic_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_en,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output logic       pop_valid,
    input  logic       pop_ready,
    output result_t    pop_data
);

    result_t                mem_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0]  cnt_reg,    cnt_next;
    logic [Q_PTR_BITS-1:0]  wr_ptr_b;
    logic [Q_CNT_BITS-1:0]  n_in;
    logic                   pop;

    always_comb begin
        // two free entries needed before a word may come in
        room      = cnt_reg <= Q_CNT_BITS'(Q_DEPTH - 2);
        pop_valid = cnt_reg != '0;
        pop_data  = mem_reg[rd_ptr_reg];
        pop       = pop_valid & pop_ready;
        n_in      = push_en ? Q_CNT_BITS'(push_count) : '0;
        wr_ptr_b  = wr_ptr_reg + Q_PTR_BITS'(1);

        wr_ptr_next = wr_ptr_reg + Q_PTR_BITS'(n_in);
        rd_ptr_next = rd_ptr_reg + Q_PTR_BITS'(pop);
        cnt_next    = cnt_reg + n_in - Q_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_en && push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_en && push_count == 2'd2) begin
            mem_reg[wr_ptr_b] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
